>>> hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is released.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/lpgtf_pkg.sv
`timescale 1ns / 1ps
package lpgtf_pkg;

    // Default coordinate width in bits
    localparam int COORD_WIDTH_DEF = 19;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 2'd2;

    // Reset of the height floor: -5 m in 1/1024 m
    localparam int MIN_HEIGHT_RST = -5120;

    // cos and sin of 0.205 deg in Q30
    localparam logic signed [31:0] COS_Q30  = 32'sd1073734951;
    localparam logic signed [31:0] SIN_Q30  = 32'sd3841759;
    localparam int                 FRAC_BITS = 30;

    // Per-stage control that travels with each word
    typedef struct packed {
        logic valid;
        logic keep;
        logic hzero;
    } lpg_ctl_t;

endpackage

>>> hdl/lpgtf_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module lpgtf_isqrt #(
    parameter int W      = lpgtf_pkg::COORD_WIDTH_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  lpgtf_pkg::lpg_ctl_t  in_ctl,
    input  logic [2*W-1:0]       in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output lpgtf_pkg::lpg_ctl_t  out_ctl,
    output logic [W-1:0]         out_root,
    output logic [SIDE_W-1:0]    out_side
);
    import lpgtf_pkg::*;

    lpg_ctl_t          ctl_reg  [W];
    logic [2*W-1:0]    rad_reg  [W];
    logic [W+1:0]      rem_reg  [W];
    logic [W-1:0]      root_reg [W];
    logic [SIDE_W-1:0] side_reg [W];

    for (genvar k = 0; k < W; k++) begin : g_step
        lpg_ctl_t          ctl_in;
        logic [2*W-1:0]    rad_in;
        logic [W+1:0]      rem_in;
        logic [W-1:0]      root_in;
        logic [SIDE_W-1:0] side_in;
        logic [W+1:0]      rem_sh;
        logic [W+1:0]      trial;
        logic [W+1:0]      rem_next;
        logic [W-1:0]      root_next;
        logic [2*W-1:0]    rad_next;
        logic              ge;

        if (k == 0) begin : g_first
            assign ctl_in  = in_ctl;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign ctl_in  = ctl_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // Bring down two radicand bits and try the next root bit
        always_comb begin
            rem_sh    = {rem_in[W-1:0], rad_in[2*W-1 -: 2]};
            trial     = {root_in, 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_in[W-2:0], ge};
            rad_next  = {rad_in[2*W-3:0], 2'b00};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k] <= '0;
            end else if (en) begin
                ctl_reg[k] <= ctl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= rad_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_ctl  = ctl_reg[W-1];
    assign out_root = root_reg[W-1];
    assign out_side = side_reg[W-1];

endmodule

>>> hdl/lpgtf_div.sv
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider, one quotient bit per stage.
// The quotient is known to fit in W bits, so the top half of the
// dividend seeds the partial remainder.
module lpgtf_div #(
    parameter int W      = lpgtf_pkg::COORD_WIDTH_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  lpgtf_pkg::lpg_ctl_t  in_ctl,
    input  logic [2*W-1:0]       in_dvd_a,
    input  logic [2*W-1:0]       in_dvd_b,
    input  logic [W-1:0]         in_dvs,
    input  logic [SIDE_W-1:0]    in_side,
    output lpgtf_pkg::lpg_ctl_t  out_ctl,
    output logic [W-1:0]         out_q_a,
    output logic [W-1:0]         out_q_b,
    output logic [SIDE_W-1:0]    out_side
);
    import lpgtf_pkg::*;

    lpg_ctl_t          ctl_reg   [W];
    logic [W-1:0]      dvd_a_reg [W];
    logic [W-1:0]      dvd_b_reg [W];
    logic [W:0]        rem_a_reg [W];
    logic [W:0]        rem_b_reg [W];
    logic [W-1:0]      q_a_reg   [W];
    logic [W-1:0]      q_b_reg   [W];
    logic [W-1:0]      dvs_reg   [W];
    logic [SIDE_W-1:0] side_reg  [W];

    for (genvar k = 0; k < W; k++) begin : g_step
        lpg_ctl_t          ctl_in;
        logic [W-1:0]      dvd_a_in, dvd_b_in, q_a_in, q_b_in, dvs_in;
        logic [W:0]        rem_a_in, rem_b_in;
        logic [SIDE_W-1:0] side_in;
        logic [W:0]        sh_a, sh_b, dvs_ext, rem_a_next, rem_b_next;
        logic [W-1:0]      q_a_next, q_b_next, dvd_a_next, dvd_b_next;
        logic              ge_a, ge_b;

        if (k == 0) begin : g_first
            assign ctl_in   = in_ctl;
            assign dvd_a_in = in_dvd_a[W-1:0];
            assign dvd_b_in = in_dvd_b[W-1:0];
            assign rem_a_in = {1'b0, in_dvd_a[2*W-1:W]};
            assign rem_b_in = {1'b0, in_dvd_b[2*W-1:W]};
            assign q_a_in   = '0;
            assign q_b_in   = '0;
            assign dvs_in   = in_dvs;
            assign side_in  = in_side;
        end else begin : g_rest
            assign ctl_in   = ctl_reg[k-1];
            assign dvd_a_in = dvd_a_reg[k-1];
            assign dvd_b_in = dvd_b_reg[k-1];
            assign rem_a_in = rem_a_reg[k-1];
            assign rem_b_in = rem_b_reg[k-1];
            assign q_a_in   = q_a_reg[k-1];
            assign q_b_in   = q_b_reg[k-1];
            assign dvs_in   = dvs_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        // Shift in the next dividend bit and subtract where it fits
        always_comb begin
            dvs_ext    = {1'b0, dvs_in};
            sh_a       = {rem_a_in[W-1:0], dvd_a_in[W-1]};
            sh_b       = {rem_b_in[W-1:0], dvd_b_in[W-1]};
            ge_a       = (sh_a >= dvs_ext);
            ge_b       = (sh_b >= dvs_ext);
            rem_a_next = ge_a ? (sh_a - dvs_ext) : sh_a;
            rem_b_next = ge_b ? (sh_b - dvs_ext) : sh_b;
            q_a_next   = {q_a_in[W-2:0], ge_a};
            q_b_next   = {q_b_in[W-2:0], ge_b};
            dvd_a_next = {dvd_a_in[W-2:0], 1'b0};
            dvd_b_next = {dvd_b_in[W-2:0], 1'b0};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[k] <= '0;
            end else if (en) begin
                ctl_reg[k] <= ctl_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dvd_a_reg[k] <= dvd_a_next;
                dvd_b_reg[k] <= dvd_b_next;
                rem_a_reg[k] <= rem_a_next;
                rem_b_reg[k] <= rem_b_next;
                q_a_reg[k]   <= q_a_next;
                q_b_reg[k]   <= q_b_next;
                dvs_reg[k]   <= dvs_in;
                side_reg[k]  <= side_in;
            end
        end
    end

    assign out_ctl  = ctl_reg[W-1];
    assign out_q_a  = q_a_reg[W-1];
    assign out_q_b  = q_b_reg[W-1];
    assign out_side = side_reg[W-1];

endmodule

>>> hdl/lpgtf_rot.sv
`timescale 1ns / 1ps
// Rotation datapath: products, Q30 sums with rounding, then saturation
// into the output register.
module lpgtf_rot #(
    parameter int W = lpgtf_pkg::COORD_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  lpgtf_pkg::lpg_ctl_t  in_ctl,
    input  logic [W-1:0]         in_x,
    input  logic [W-1:0]         in_y,
    input  logic [W-1:0]         in_z,
    input  logic [W-1:0]         in_h,
    input  logic [W-1:0]         in_qx,
    input  logic [W-1:0]         in_qy,
    input  logic                 in_neg_x,
    input  logic                 in_neg_y,
    output logic                 out_valid,
    output logic [W-1:0]         out_x,
    output logic [W-1:0]         out_y,
    output logic [W-1:0]         out_z
);
    import lpgtf_pkg::*;

    localparam int ACC_W = W + 34;

    lpg_ctl_t                ctl1_reg, ctl2_reg;
    logic signed [ACC_W-1:0] cx_reg, cy_reg, cz_reg, sx_reg, sy_reg, sh_reg;
    logic signed [ACC_W-1:0] cx_next, cy_next, cz_next, sx_next, sy_next, sh_next;
    logic signed [ACC_W-1:0] acc_x_reg, acc_y_reg, acc_z_reg;
    logic signed [ACC_W-1:0] acc_x_next, acc_y_next, acc_z_next;
    logic signed [W:0]       qx_s, qy_s, h_s;
    logic signed [ACC_W-1:0] half;
    logic                    valid_reg;
    logic [W-1:0]            ox_reg, oy_reg, oz_reg;

    // Round down by the Q30 shift, then clamp to the signed coordinate range
    function automatic logic [W-1:0] sat_shift(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        logic [W-1:0]            r;
        t = acc >>> FRAC_BITS;
        if (&t[ACC_W-1:W-1] || ~|t[ACC_W-1:W-1]) begin
            r = t[W-1:0];
        end else if (t[ACC_W-1]) begin
            r = {1'b1, {(W-1){1'b0}}};
        end else begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    // Signed quotients and the horizontal distance
    always_comb begin
        qx_s = in_neg_x ? -$signed({1'b0, in_qx}) : $signed({1'b0, in_qx});
        qy_s = in_neg_y ? -$signed({1'b0, in_qy}) : $signed({1'b0, in_qy});
        h_s  = $signed({1'b0, in_h});
        half = ACC_W'(1) <<< (FRAC_BITS - 1);
    end

    // Stage one: products, sine terms dropped when the horizontal distance is zero
    always_comb begin
        cx_next = ACC_W'(COS_Q30) * ACC_W'($signed(in_x));
        cy_next = ACC_W'(COS_Q30) * ACC_W'($signed(in_y));
        cz_next = ACC_W'(COS_Q30) * ACC_W'($signed(in_z));
        sx_next = in_ctl.hzero ? '0 : ACC_W'(SIN_Q30) * ACC_W'(qx_s);
        sy_next = in_ctl.hzero ? '0 : ACC_W'(SIN_Q30) * ACC_W'(qy_s);
        sh_next = in_ctl.hzero ? '0 : ACC_W'(SIN_Q30) * ACC_W'(h_s);
    end

    // Stage two: sums with the rounding half
    always_comb begin
        acc_x_next = cx_reg - sx_reg + half;
        acc_y_next = cy_reg - sy_reg + half;
        acc_z_next = cz_reg + sh_reg + half;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg  <= '0;
            ctl2_reg  <= '0;
            valid_reg <= 1'b0;
        end else if (en) begin
            ctl1_reg  <= in_ctl;
            ctl2_reg  <= ctl1_reg;
            valid_reg <= ctl2_reg.valid & ctl2_reg.keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            cz_reg    <= cz_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            sh_reg    <= sh_next;
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            acc_z_reg <= acc_z_next;
            ox_reg    <= sat_shift(acc_x_reg);
            oy_reg    <= sat_shift(acc_y_reg);
            oz_reg    <= sat_shift(acc_z_reg);
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;

endmodule

>>> hdl/lidar_point_gate_and_tilt_fix_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                          Word
// s_        in         s_tvalid s_tready s_tdata      one lidar point
// m_        out        m_tvalid m_tready m_tdata      one corrected point
// cfg_      in         cfg_valid cfg_ready cfg_index  gate register write
//                      cfg_data
//
// One point enters per cycle unless m_tready stalls; depth is set by the
// square root and divider pipelines, each one bit per stage.
// Dropped points leave a bubble and produce no output word.
// aresetn is synchronous; it clears the valid bits and loads register defaults.
// A stall on m_tready freezes the whole pipeline; s_tready follows it.
module lidar_point_gate_and_tilt_fix_core #(
    parameter int COORD_WIDTH = lpgtf_pkg::COORD_WIDTH_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // pos_x, pos_y, pos_z, zero pad
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // out_x, out_y, out_z, zero pad
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]        m_tdata,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [lpgtf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [COORD_WIDTH-1:0]                    cfg_data
);
    import lpgtf_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int TW      = ((3*W+7)/8)*8;
    localparam int SQ_SIDE = 7*W + 2;
    localparam int DV_SIDE = 4*W + 2;

    logic                en;
    logic [W-2:0]        min_range_reg, max_range_reg;
    logic [W-1:0]        min_height_reg;
    logic [2*W-3:0]      min_sq_reg, max_sq_reg;

    lpg_ctl_t            ctl1_reg, ctl2_reg, ctl3_reg;
    logic [W-1:0]        x1_reg, y1_reg, z1_reg;
    logic [W-1:0]        x2_reg, y2_reg, z2_reg;
    logic [2*W-1:0]      xx_reg, yy_reg, zz_reg;
    logic signed [2*W-1:0] xz_reg, yz_reg;
    logic                zok_reg;
    logic [W-1:0]        mx, my, mz;
    logic [W-1:0]        x3_reg, y3_reg, z3_reg;
    logic [2*W-1:0]      h2_reg, xzm_reg, yzm_reg;
    logic                nx_reg, ny_reg;
    logic [2*W-1:0]      h2_next;
    logic [2*W:0]        r2_next;
    lpg_ctl_t            ctl3_next;

    lpg_ctl_t            sq_ctl;
    logic [W-1:0]        sq_root;
    logic [SQ_SIDE-1:0]  sq_side;
    lpg_ctl_t            dv_ctl;
    logic [W-1:0]        q_a, q_b;
    logic [DV_SIDE-1:0]  dv_side;
    logic [W-1:0]        ox, oy, oz;

    // Advance whenever the output register is free or being drained
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // Gate registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_range_reg  <= '0;
            max_range_reg  <= '1;
            min_height_reg <= W'(MIN_HEIGHT_RST);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_RANGE:  min_range_reg  <= cfg_data[W-2:0];
                REG_MAX_RANGE:  max_range_reg  <= cfg_data[W-2:0];
                REG_MIN_HEIGHT: min_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold squared range bounds
    always_ff @(posedge aclk) begin
        min_sq_reg <= (2*W-2)'(min_range_reg) * (2*W-2)'(min_range_reg);
        max_sq_reg <= (2*W-2)'(max_range_reg) * (2*W-2)'(max_range_reg);
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end else if (en) begin
            ctl1_reg <= '{valid: s_tvalid, keep: 1'b0, hzero: 1'b0};
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl3_next;
        end
    end

    // Magnitudes for the squares
    always_comb begin
        mx = x1_reg[W-1] ? (~x1_reg + 1'b1) : x1_reg;
        my = y1_reg[W-1] ? (~y1_reg + 1'b1) : y1_reg;
        mz = z1_reg[W-1] ? (~z1_reg + 1'b1) : z1_reg;
    end

    // Range test on squares and height test
    always_comb begin
        h2_next         = xx_reg + yy_reg;
        r2_next         = {1'b0, h2_next} + {1'b0, zz_reg};
        ctl3_next       = ctl2_reg;
        ctl3_next.keep  = zok_reg && (r2_next > {3'b0, min_sq_reg})
                          && (r2_next < {3'b0, max_sq_reg});
        ctl3_next.hzero = (h2_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg  <= s_tdata[W-1:0];
            y1_reg  <= s_tdata[2*W-1:W];
            z1_reg  <= s_tdata[3*W-1:2*W];
            xx_reg  <= (2*W)'(mx) * (2*W)'(mx);
            yy_reg  <= (2*W)'(my) * (2*W)'(my);
            zz_reg  <= (2*W)'(mz) * (2*W)'(mz);
            xz_reg  <= (2*W)'($signed(x1_reg)) * (2*W)'($signed(z1_reg));
            yz_reg  <= (2*W)'($signed(y1_reg)) * (2*W)'($signed(z1_reg));
            zok_reg <= $signed(z1_reg) > $signed(min_height_reg);
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            z2_reg  <= z1_reg;
            h2_reg  <= h2_next;
            xzm_reg <= xz_reg[2*W-1] ? (~xz_reg + 1'b1) : xz_reg;
            yzm_reg <= yz_reg[2*W-1] ? (~yz_reg + 1'b1) : yz_reg;
            nx_reg  <= xz_reg[2*W-1];
            ny_reg  <= yz_reg[2*W-1];
            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
            z3_reg  <= z2_reg;
        end
    end

    lpgtf_isqrt #(.W(W), .SIDE_W(SQ_SIDE)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctl   (ctl3_reg),
        .in_rad   (h2_reg),
        .in_side  ({nx_reg, ny_reg, yzm_reg, xzm_reg, z3_reg, y3_reg, x3_reg}),
        .out_ctl  (sq_ctl),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    lpgtf_div #(.W(W), .SIDE_W(DV_SIDE)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_ctl   (sq_ctl),
        .in_dvd_a (sq_side[5*W-1:3*W]),
        .in_dvd_b (sq_side[7*W-1:5*W]),
        .in_dvs   (sq_root),
        .in_side  ({sq_side[7*W+1:7*W], sq_root, sq_side[3*W-1:0]}),
        .out_ctl  (dv_ctl),
        .out_q_a  (q_a),
        .out_q_b  (q_b),
        .out_side (dv_side)
    );

    lpgtf_rot #(.W(W)) u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_ctl    (dv_ctl),
        .in_x      (dv_side[W-1:0]),
        .in_y      (dv_side[2*W-1:W]),
        .in_z      (dv_side[3*W-1:2*W]),
        .in_h      (dv_side[4*W-1:3*W]),
        .in_qx     (q_a),
        .in_qy     (q_b),
        .in_neg_x  (dv_side[4*W+1]),
        .in_neg_y  (dv_side[4*W]),
        .out_valid (m_tvalid),
        .out_x     (ox),
        .out_y     (oy),
        .out_z     (oz)
    );

    assign m_tdata = TW'({oz, oy, ox});

endmodule

>>> hdl/lpgtf_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks on the core.
module lpgtf_chk #(
    parameter int COORD_WIDTH = lpgtf_pkg::COORD_WIDTH_DEF
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata
);
    // Output valid is low in the cycle after reset is asserted
    `CHK_ASSERT_ALWAYS(a_rst_clears, aclk, !aresetn |=> !m_tvalid, "m_tvalid after reset")

    // Input side opens exactly when the output word is free or drained
    `CHK_ASSERT(a_ready_link, aclk, aresetn, s_tready == (!m_tvalid || m_tready), "s_tready mismatch")

    // A stalled output word holds
    `CHK_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output word changed under stall")

endmodule

bind lidar_point_gate_and_tilt_fix_core lpgtf_chk #(.COORD_WIDTH(COORD_WIDTH)) u_lpgtf_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
